// File: sv/upkm_pkg.sv
// ----------------------------------------------------------------------------
// upkm_pkg
// Shared widths, codes and types of the unique-prefix keyword matcher.
// ----------------------------------------------------------------------------
package upkm_pkg;

	localparam int TABLE_ENTRIES_DEF  = 16;
	localparam int KEYWORD_LENGTH_DEF = 16;

	localparam int CHAR_W   = 8;
	localparam int SLOT_W   = 4;
	localparam int POS_W    = 4;
	localparam int IDX_W    = 4;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;

	// item action codes
	localparam logic ACT_TABLE = 1'b0;
	localparam logic ACT_KEY   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_FOUND   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_AMBIG   = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    match_index;
	} res_t;

endpackage

// File: sv/upkm_if.sv
// ----------------------------------------------------------------------------
// upkm_if
// Valid/ready channels of the matcher: item beats in, result beats out.
// ----------------------------------------------------------------------------
interface upkm_item_if
	import upkm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              action;
	logic [SLOT_W-1:0] entry_slot;
	logic [POS_W-1:0]  char_position;
	logic [CHAR_W-1:0] char_code;
	logic              exact_only;

	modport source (output valid, action, entry_slot, char_position, char_code, exact_only,
		input ready);
	modport sink (input valid, action, entry_slot, char_position, char_code, exact_only,
		output ready);
endinterface

interface upkm_result_if
	import upkm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    match_index;

	modport source (output valid, status, match_index, input ready);
	modport sink (input valid, status, match_index, output ready);
endinterface

// File: sv/upkm_kwmem.sv
// ----------------------------------------------------------------------------
// upkm_kwmem
// Keyword character store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module upkm_kwmem
	import upkm_pkg::*;
#(
	parameter int DEPTH = TABLE_ENTRIES_DEF * KEYWORD_LENGTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/upkm_ctrl.sv
// ----------------------------------------------------------------------------
// upkm_ctrl
// Sequencer: clearing sweep, table writes, per-entry scan over the keyword
// store for each key beat, and the final lookup decision.
// ----------------------------------------------------------------------------
module upkm_ctrl
	import upkm_pkg::*;
#(
	parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
	parameter int KEYWORD_LENGTH = KEYWORD_LENGTH_DEF,
	parameter int AW             = $clog2(TABLE_ENTRIES * KEYWORD_LENGTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	upkm_item_if.sink         item,
	input  logic [CFG_W-1:0]  entries_in_use,
	input  logic              out_free,
	output logic              res_push,
	output res_t              res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [CHAR_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [CHAR_W-1:0] mem_rdata
);

	localparam int DEPTH = TABLE_ENTRIES * KEYWORD_LENGTH;
	localparam int EW    = $clog2(TABLE_ENTRIES);
	localparam int PW    = $clog2(KEYWORD_LENGTH);
	localparam int KPW   = $clog2(KEYWORD_LENGTH + 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]               state_q;
	logic [AW-1:0]            clr_q;
	logic [KPW-1:0]           key_pos_q;
	logic [TABLE_ENTRIES-1:0] flags_q;
	logic [CHAR_W-1:0]        ch_q;
	logic                     exact_only_q;
	logic                     end_q;
	logic                     zero_q;
	logic [EW-1:0]            last_q;
	logic [EW-1:0]            scan_q;
	logic                     issue_done_q;
	logic                     v_s1;
	logic [EW-1:0]            e_s1;
	logic                     exact_q;
	logic [EW-1:0]            exact_idx_q;
	logic [1:0]               abbr_cnt_q;
	logic [EW-1:0]            abbr_idx_q;

	logic              accept;
	logic              key_full;
	logic              tbl_in_range;
	logic              issuing;
	logic [CHAR_W-1:0] byte_s1;
	int                n_act;

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;
	assign key_full     = (int'(key_pos_q) >= KEYWORD_LENGTH);
	assign tbl_in_range = (int'(item.entry_slot) < TABLE_ENTRIES)
		&& (int'(item.char_position) < KEYWORD_LENGTH);
	assign issuing      = (state_q == ST_SCAN) && !issue_done_q;
	assign byte_s1      = zero_q ? '0 : mem_rdata;
	assign n_act        = (int'(entries_in_use) > TABLE_ENTRIES) ? TABLE_ENTRIES
		: int'(entries_in_use);

	// memory port muxing: clearing sweep or table write, scan reads
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && item.action == ACT_TABLE && tbl_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(EW'(item.entry_slot)) * AW'(KEYWORD_LENGTH)
				+ AW'(PW'(item.char_position));
			mem_wdata = item.char_code;
		end
	end

	assign mem_re    = issuing && !zero_q;
	assign mem_raddr = AW'(scan_q) * AW'(KEYWORD_LENGTH) + AW'(PW'(key_pos_q));

	// final decision
	always_comb begin
		res_push        = (state_q == ST_DONE) && out_free;
		res.status      = STAT_NOMATCH;
		res.match_index = '0;
		if (exact_q) begin
			res.status      = STAT_FOUND;
			res.match_index = IDX_W'(exact_idx_q);
		end else if (!exact_only_q && abbr_cnt_q == 2'd1) begin
			res.status      = STAT_FOUND;
			res.match_index = IDX_W'(abbr_idx_q);
		end else if (abbr_cnt_q == 2'd2) begin
			res.status = STAT_AMBIG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			key_pos_q    <= '0;
			flags_q      <= '1;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			exact_q      <= 1'b0;
			abbr_cnt_q   <= '0;
			end_q        <= 1'b0;
			zero_q       <= 1'b0;
		end else begin
			v_s1 <= issuing;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept && item.action == ACT_KEY) begin
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						if (item.char_code != '0) begin
							if (key_full) begin
								// key overran the entry length
								flags_q <= '0;
							end else begin
								ch_q    <= item.char_code;
								end_q   <= 1'b0;
								zero_q  <= 1'b0;
								last_q  <= EW'(TABLE_ENTRIES - 1);
								state_q <= ST_SCAN;
							end
						end else begin
							exact_only_q <= item.exact_only;
							exact_q      <= 1'b0;
							abbr_cnt_q   <= '0;
							end_q        <= 1'b1;
							zero_q       <= key_full;
							last_q       <= EW'(n_act - 1);
							state_q      <= (n_act == 0) ? ST_DONE : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						scan_q <= scan_q + EW'(1);
						e_s1   <= scan_q;
						if (scan_q == last_q) begin
							issue_done_q <= 1'b1;
						end
					end
					if (v_s1) begin
						if (!end_q) begin
							if (byte_s1 != ch_q) begin
								flags_q[e_s1] <= 1'b0;
							end
						end else if (flags_q[e_s1] && !exact_q) begin
							if (byte_s1 == '0) begin
								exact_q     <= 1'b1;
								exact_idx_q <= e_s1;
							end else begin
								abbr_idx_q <= e_s1;
								if (abbr_cnt_q != 2'd2) begin
									abbr_cnt_q <= abbr_cnt_q + 2'd1;
								end
							end
						end
					end
					// last compare lands in the cycle after the last read
					if (issue_done_q) begin
						if (end_q) begin
							state_q <= ST_DONE;
						end else begin
							key_pos_q <= key_pos_q + KPW'(1);
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						flags_q   <= '1;
						key_pos_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/unique_prefix_keyword_matcher.sv
// ----------------------------------------------------------------------------
// unique_prefix_keyword_matcher
// Keyword table lookup that accepts unique abbreviations of stored keywords.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// item      in   table char write (action 0) or next key char (action 1)
// result    out  status and match_index, one beat per key-ending item
// cfg       in   entries_in_use, written on cfg_wr_en
//
// Steps: a table write is taken at its accept alone, and so is a key char past the
// entry length. A key char is the accept, one store read per entry for all
// TABLE_ENTRIES entries through the single read port, and the compare of the last read.
// A key end scans only the n active entries the same way, then pushes its result.
// Reset: a clearing sweep over all TABLE_ENTRIES * KEYWORD_LENGTH words zeroes
// the keyword store; item.ready stays low until it ends.
// Stalls: the result register holds one beat; the block keeps taking items
// while it waits and only a key end stalls if the previous result is unread.
// ----------------------------------------------------------------------------
module unique_prefix_keyword_matcher
	import upkm_pkg::*;
#(
	parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
	parameter int KEYWORD_LENGTH = KEYWORD_LENGTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	upkm_item_if.sink        item,
	upkm_result_if.source    result,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	localparam int DEPTH = TABLE_ENTRIES * KEYWORD_LENGTH;
	localparam int AW    = $clog2(DEPTH);

	logic [CFG_W-1:0]  entries_in_use_q;
	logic              res_valid_q;
	res_t              res_q;
	logic              out_free;
	logic              res_push;
	res_t              res;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CHAR_W-1:0] mem_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (cfg_wr_en) begin
			entries_in_use_q <= cfg_wr_data;
		end
	end

	upkm_ctrl #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.KEYWORD_LENGTH (KEYWORD_LENGTH),
		.AW             (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.entries_in_use (entries_in_use_q),
		.out_free       (out_free),
		.res_push       (res_push),
		.res            (res),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	upkm_kwmem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_kwmem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// result register: parts the sequencer from the result consumer
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.status      = res_q.status;
	assign result.match_index = res_q.match_index;

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res_valid_q || result.ready))
		else $error("result register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> result.valid)
		else $error("pushed result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status == STAT_FOUND || result.status == STAT_NOMATCH
			|| result.status == STAT_AMBIG))
		else $error("bad status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != STAT_FOUND) |-> (result.match_index == '0))
		else $error("index nonzero without a match");

endmodule
